// File: rtl/dst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_pkg
// Shared constants and types of the display scanline status timer.
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int LINE_W   = 9;
  localparam int STATUS_W = 16;
  localparam int IRQ_W    = 3;
  localparam int MODE_W   = 2;

  // Line numbers, one bit wider than the counter so an increment never wraps
  localparam logic [LINE_W:0] VISIBLE_LINES = (LINE_W + 1)'(192);
  localparam logic [LINE_W:0] TOTAL_LINES   = (LINE_W + 1)'(263);

  localparam logic [STATUS_W-1:0] WRITE_MASK = 16'hFFB8;

  // Event codes
  localparam logic [MODE_W-1:0] MODE_HBLANK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINEEND = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE_A = 2'd2;
  localparam logic [MODE_W-1:0] MODE_WRITE_B = 2'd3;

  // Status word bit positions
  localparam int ST_VBLANK    = 0;
  localparam int ST_HBLANK    = 1;
  localparam int ST_MATCH     = 2;
  localparam int ST_VBLANK_EN = 3;
  localparam int ST_HBLANK_EN = 4;
  localparam int ST_MATCH_EN  = 5;
  localparam int ST_CMP_MSB   = 7;

  // Interrupt request bit positions
  localparam int IRQ_VBLANK = 0;
  localparam int IRQ_HBLANK = 1;
  localparam int IRQ_MATCH  = 2;

  // Line events decoded once and applied to both status words
  typedef struct packed {
    logic              hblank_start;
    logic              line_end;
    logic              vblank_set;
    logic              vblank_clr;
    logic [LINE_W-1:0] line;
  } line_evt_t;

  typedef struct packed {
    logic dma_a_vblank;
    logic dma_b_vblank;
    logic dma_b_hblank;
    logic dma_b_display_start;
    logic render_line_valid;
  } pulse_t;

endpackage

// File: rtl/dst_line_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_line_unit
// Line counter next value, vblank decode and the render / DMA pulses.
// ----------------------------------------------------------------------------
module dst_line_unit (
  input  logic [dst_pkg::MODE_W-1:0] mode,
  input  logic [dst_pkg::LINE_W-1:0] line_cur,
  output logic [dst_pkg::LINE_W-1:0] line_nxt,
  output dst_pkg::line_evt_t         evt,
  output dst_pkg::pulse_t            pulse
);
  import dst_pkg::*;

  logic            hb;
  logic            le;
  logic [LINE_W:0] line_ext;
  logic [LINE_W:0] line_inc;
  logic [LINE_W:0] line_wrap;

  assign hb        = (mode == MODE_HBLANK);
  assign le        = (mode == MODE_LINEEND);
  assign line_ext  = {1'b0, line_cur};
  assign line_inc  = line_ext + (LINE_W + 1)'(1);
  assign line_wrap = (line_inc >= TOTAL_LINES) ? '0 : line_inc;
  assign line_nxt  = le ? line_wrap[LINE_W-1:0] : line_cur;

  always_comb begin
    evt.hblank_start = hb;
    evt.line_end     = le;
    evt.vblank_set   = le && (line_inc == VISIBLE_LINES);
    // vblank start wins when both line numbers coincide
    evt.vblank_clr   = le && (line_inc != VISIBLE_LINES) &&
                       (line_inc == TOTAL_LINES - (LINE_W + 1)'(1));
    evt.line         = line_nxt;

    pulse.dma_a_vblank        = evt.vblank_set;
    pulse.dma_b_vblank        = evt.vblank_set;
    pulse.render_line_valid   = hb && (line_ext < VISIBLE_LINES);
    pulse.dma_b_hblank        = hb && (line_ext < VISIBLE_LINES);
    pulse.dma_b_display_start = hb && (line_ext > (LINE_W + 1)'(1)) &&
                                (line_ext < VISIBLE_LINES + (LINE_W + 1)'(2));
  end

endmodule

// File: rtl/dst_status_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_status_unit
// Next value and interrupt requests of one processor's status word.
// ----------------------------------------------------------------------------
module dst_status_unit (
  input  logic [dst_pkg::STATUS_W-1:0] status_cur,
  input  dst_pkg::line_evt_t           evt,
  input  logic                         wr_en,
  input  logic [dst_pkg::STATUS_W-1:0] wr_data,
  output logic [dst_pkg::STATUS_W-1:0] status_nxt,
  output logic [dst_pkg::IRQ_W-1:0]    irq
);
  import dst_pkg::*;

  logic [LINE_W-1:0] cmp;

  assign cmp = {status_cur[ST_CMP_MSB], status_cur[STATUS_W-1:8]};

  always_comb begin
    status_nxt = status_cur;
    irq        = '0;
    if (evt.hblank_start) begin
      status_nxt[ST_HBLANK] = 1'b1;
      irq[IRQ_HBLANK]       = status_cur[ST_HBLANK_EN];
    end else if (evt.line_end) begin
      if (evt.vblank_set) begin
        status_nxt[ST_VBLANK] = 1'b1;
        irq[IRQ_VBLANK]       = status_cur[ST_VBLANK_EN];
      end else if (evt.vblank_clr) begin
        status_nxt[ST_VBLANK] = 1'b0;
      end
      // compare against the line after increment and wrap
      if (cmp == evt.line) begin
        status_nxt[ST_MATCH] = 1'b1;
        irq[IRQ_MATCH]       = status_cur[ST_MATCH_EN];
      end else begin
        status_nxt[ST_MATCH] = 1'b0;
      end
      status_nxt[ST_HBLANK] = 1'b0;
    end else if (wr_en) begin
      status_nxt = (status_cur & ~WRITE_MASK) | (wr_data & WRITE_MASK);
    end
  end

endmodule

// File: rtl/display_scanline_status_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_scanline_status_timer
// Scanline counter with two display status words and line compare.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one event: hblank start, line end, or
// a write of status word A or B (only bits 0xFFB8 are taken). The event is
// captured in an input register, decoded in a single combinational pass
// against the line counter and both status words, and its result (counter,
// both status words, interrupt requests and DMA / render pulses) lands in the
// output register once that register is free. An event thus passes the input
// register and then the output register before its result can transfer.
// The block sustains one event per cycle: a new event is taken every cycle
// as long as the result side keeps transferring, and the output register
// lets the input side run one event ahead while a finished result waits.
// The counter wraps at 263 lines; vblank is raised entering line 192 and
// dropped entering line 262. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module display_scanline_status_timer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dst_pkg::MODE_W-1:0]   in_mode,
  input  logic [dst_pkg::STATUS_W-1:0] in_write_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dst_pkg::LINE_W-1:0]   out_line_count,
  output logic [dst_pkg::STATUS_W-1:0] out_status_a,
  output logic [dst_pkg::STATUS_W-1:0] out_status_b,
  output logic [dst_pkg::IRQ_W-1:0]    out_irq_a,
  output logic [dst_pkg::IRQ_W-1:0]    out_irq_b,
  output logic                         out_dma_a_vblank,
  output logic                         out_dma_b_vblank,
  output logic                         out_dma_b_hblank,
  output logic                         out_dma_b_display_start,
  output logic                         out_render_line_valid
);
  import dst_pkg::*;

  // Architectural state
  logic [LINE_W-1:0]   line_r;
  logic [STATUS_W-1:0] status_a_r;
  logic [STATUS_W-1:0] status_b_r;

  // Input register
  logic                in_vld_r;
  logic [MODE_W-1:0]   mode_r;
  logic [STATUS_W-1:0] data_r;

  // Output register
  logic                out_vld_r;
  logic [IRQ_W-1:0]    irq_a_r;
  logic [IRQ_W-1:0]    irq_b_r;
  pulse_t              pulse_r;

  logic                out_load;
  logic                exec;
  logic [LINE_W-1:0]   line_nxt;
  logic [STATUS_W-1:0] status_a_nxt;
  logic [STATUS_W-1:0] status_b_nxt;
  logic [IRQ_W-1:0]    irq_a_nxt;
  logic [IRQ_W-1:0]    irq_b_nxt;
  line_evt_t           evt;
  pulse_t              pulse_nxt;

  // Output register is free when empty or being transferred this cycle
  assign out_load = !out_vld_r || !out_stall;
  assign exec     = in_vld_r && out_load;
  // Hold the input side only while the captured event cannot advance
  assign in_stall = in_vld_r && !out_load;

  dst_line_unit u_line (
    .mode     (mode_r),
    .line_cur (line_r),
    .line_nxt (line_nxt),
    .evt      (evt),
    .pulse    (pulse_nxt)
  );

  dst_status_unit u_status_a (
    .status_cur (status_a_r),
    .evt        (evt),
    .wr_en      (mode_r == MODE_WRITE_A),
    .wr_data    (data_r),
    .status_nxt (status_a_nxt),
    .irq        (irq_a_nxt)
  );

  dst_status_unit u_status_b (
    .status_cur (status_b_r),
    .evt        (evt),
    .wr_en      (mode_r == MODE_WRITE_B),
    .wr_data    (data_r),
    .status_nxt (status_b_nxt),
    .irq        (irq_b_nxt)
  );

  // Capture a new event whenever the input register is empty or advancing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      mode_r <= in_mode;
      data_r <= in_write_data;
    end
  end

  // Commit state and result together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r     <= '0;
      status_a_r <= '0;
      status_b_r <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      if (exec) begin
        line_r     <= line_nxt;
        status_a_r <= status_a_nxt;
        status_b_r <= status_b_nxt;
      end
      if (out_load) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      irq_a_r <= irq_a_nxt;
      irq_b_r <= irq_b_nxt;
      pulse_r <= pulse_nxt;
    end
  end

  // Counter and status words only change on exec, so they double as the
  // result payload
  assign out_valid               = out_vld_r;
  assign out_line_count          = line_r;
  assign out_status_a            = status_a_r;
  assign out_status_b            = status_b_r;
  assign out_irq_a               = irq_a_r;
  assign out_irq_b               = irq_b_r;
  assign out_dma_a_vblank        = pulse_r.dma_a_vblank;
  assign out_dma_b_vblank        = pulse_r.dma_b_vblank;
  assign out_dma_b_hblank        = pulse_r.dma_b_hblank;
  assign out_dma_b_display_start = pulse_r.dma_b_display_start;
  assign out_render_line_valid   = pulse_r.render_line_valid;

endmodule

// File: rtl/dst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks of the display scanline status timer.
// ----------------------------------------------------------------------------
module dst_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dst_pkg::LINE_W-1:0]   out_line_count,
  input logic [dst_pkg::STATUS_W-1:0] out_status_a,
  input logic [dst_pkg::IRQ_W-1:0]    out_irq_a,
  input logic                         out_dma_a_vblank,
  input logic                         out_dma_b_hblank,
  input logic                         out_render_line_valid
);
  import dst_pkg::*;

  // Counter never reaches the wrap value
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_line_count} < TOTAL_LINES))
    else $error("line count past wrap");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_line_count) &&
                               $stable(out_status_a))
    else $error("stalled result changed");

  // Vblank DMA only entering the first blank line, with the flag set
  a_vblank_dma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dma_a_vblank |->
      ({1'b0, out_line_count} == VISIBLE_LINES) && out_status_a[ST_VBLANK])
    else $error("vblank DMA off its line");

  // Hblank interrupt needs its flag and enable
  a_hblank_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_a[IRQ_HBLANK] |->
      out_status_a[ST_HBLANK] && out_status_a[ST_HBLANK_EN])
    else $error("hblank irq without flag and enable");

  // Render pulse and B hblank DMA travel together on visible lines
  a_render: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_render_line_valid |->
      out_dma_b_hblank && ({1'b0, out_line_count} < VISIBLE_LINES))
    else $error("render pulse off a visible line");

endmodule

bind display_scanline_status_timer dst_checker u_dst_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_line_count        (out_line_count),
  .out_status_a          (out_status_a),
  .out_irq_a             (out_irq_a),
  .out_dma_a_vblank      (out_dma_a_vblank),
  .out_dma_b_hblank      (out_dma_b_hblank),
  .out_render_line_valid (out_render_line_valid)
);

// File: sim/display_scanline_status_timer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// display_scanline_status_timer_tb
// Self-checking bench for the scanline counter and its two status words.
// ----------------------------------------------------------------------------
// Events go in one transfer at a time. A line model that tracks the counter
// and both status words predicts the result of every accepted event, and each
// result transfer is compared field by field with the oldest prediction. A
// short table of hand-picked events opens the run: status writes at the data
// extremes, repeated hblank, compare at its largest value and a line match.
// Random scanlines follow (optional status writes, up to two hblank starts,
// one line end) with some stray events mixed in, until enough events have
// gone in and the frame has wrapped at least twice, so vblank entry and exit,
// the wrap and a compare of zero at the top of the frame all come up. The
// sender runs in bursts, the receiver stalls in phases of varying density.
// ----------------------------------------------------------------------------
module display_scanline_status_timer_tb;
  import dst_pkg::*;

  localparam int  CLK_HALF_NS = 6;
  localparam int  N_DIR       = 17;
  localparam int  RAND_ITEMS  = 1000;
  localparam int  MIN_WRAPS   = 2;
  localparam int  END_CYCLES  = 8;
  // Well above the slowest run: ~1200 events, each with a long sender gap and
  // a receiver at its densest stall setting.
  localparam longint LIMIT_NS = 64'd400_000 * 2 * CLK_HALF_NS;

  typedef struct packed {
    logic [LINE_W-1:0]   line_count;
    logic [STATUS_W-1:0] status_a;
    logic [STATUS_W-1:0] status_b;
    logic [IRQ_W-1:0]    irq_a;
    logic [IRQ_W-1:0]    irq_b;
    logic                dma_a_vblank;
    logic                dma_b_vblank;
    logic                dma_b_hblank;
    logic                dma_b_display_start;
    logic                render_line_valid;
  } scan_result_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [STATUS_W-1:0] data;
    logic                typed;
    scan_result_t        exp;
  } event_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [MODE_W-1:0]   in_mode;
  logic [STATUS_W-1:0] in_write_data;
  logic                out_valid;
  logic                out_stall;
  logic [LINE_W-1:0]   out_line_count;
  logic [STATUS_W-1:0] out_status_a;
  logic [STATUS_W-1:0] out_status_b;
  logic [IRQ_W-1:0]    out_irq_a;
  logic [IRQ_W-1:0]    out_irq_b;
  logic                out_dma_a_vblank;
  logic                out_dma_b_vblank;
  logic                out_dma_b_hblank;
  logic                out_dma_b_display_start;
  logic                out_render_line_valid;

  // Line model state
  logic [LINE_W-1:0]   line_q;
  logic [STATUS_W-1:0] stat_a;
  logic [STATUS_W-1:0] stat_b;
  int                  frame_wraps;

  scan_result_t        expected_q[$];
  event_row_t          dir_rows[N_DIR];

  // Event on the bus right now: a typed expectation overrides the line model
  logic                row_typed;
  scan_result_t        row_exp;

  int                  n_errors;
  int                  n_items;
  int                  burst_left;
  int                  stall_pct;
  int                  stall_phase;

  display_scanline_status_timer dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_mode                 (in_mode),
    .in_write_data           (in_write_data),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_line_count          (out_line_count),
    .out_status_a            (out_status_a),
    .out_status_b            (out_status_b),
    .out_irq_a               (out_irq_a),
    .out_irq_b               (out_irq_b),
    .out_dma_a_vblank        (out_dma_a_vblank),
    .out_dma_b_vblank        (out_dma_b_vblank),
    .out_dma_b_hblank        (out_dma_b_hblank),
    .out_dma_b_display_start (out_dma_b_display_start),
    .out_render_line_valid   (out_render_line_valid)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF_NS);
    clk = 1'b1;
    #(CLK_HALF_NS);
  end

  // --------------------------------------------------------------------------
  // Line model
  // --------------------------------------------------------------------------

  // Compare value: bits 15..8 low byte, bit 7 the ninth bit.
  function automatic logic line_hit(input logic [STATUS_W-1:0] st,
                                    input logic [LINE_W-1:0] line);
    return {st[ST_CMP_MSB], st[15:8]} == line;
  endfunction

  // Apply one event to the model state and return the result it produces.
  function automatic scan_result_t scanline_advance(input logic [MODE_W-1:0] mode,
                                                    input logic [STATUS_W-1:0] data);
    scan_result_t r;
    logic [LINE_W:0] nxt;
    logic hit_a;
    logic hit_b;
    r = '0;
    case (mode)
      MODE_HBLANK: begin
        // Render and hblank DMA only on visible lines
        if ({1'b0, line_q} < VISIBLE_LINES) begin
          r.render_line_valid = 1'b1;
          r.dma_b_hblank      = 1'b1;
        end
        // Raise hblank irq on every start while enabled, flag set or not
        stat_a[ST_HBLANK] = 1'b1;
        stat_b[ST_HBLANK] = 1'b1;
        r.irq_a[IRQ_HBLANK] = stat_a[ST_HBLANK_EN];
        r.irq_b[IRQ_HBLANK] = stat_b[ST_HBLANK_EN];
        if (line_q > 1 && {1'b0, line_q} < VISIBLE_LINES + 2)
          r.dma_b_display_start = 1'b1;
      end
      MODE_LINEEND: begin
        nxt = {1'b0, line_q} + 1'b1;
        // Vblank entry wins over exit if the two line numbers coincide
        if (nxt == VISIBLE_LINES) begin
          stat_a[ST_VBLANK] = 1'b1;
          stat_b[ST_VBLANK] = 1'b1;
          r.irq_a[IRQ_VBLANK] = stat_a[ST_VBLANK_EN];
          r.irq_b[IRQ_VBLANK] = stat_b[ST_VBLANK_EN];
          r.dma_a_vblank = 1'b1;
          r.dma_b_vblank = 1'b1;
        end else if (nxt == TOTAL_LINES - 1) begin
          stat_a[ST_VBLANK] = 1'b0;
          stat_b[ST_VBLANK] = 1'b0;
        end
        if (nxt >= TOTAL_LINES) begin
          nxt = '0;
          frame_wraps++;
        end
        line_q = nxt[LINE_W-1:0];
        // Compare against the line after increment and wrap
        hit_a = line_hit(stat_a, line_q);
        hit_b = line_hit(stat_b, line_q);
        stat_a[ST_MATCH] = hit_a;
        stat_b[ST_MATCH] = hit_b;
        r.irq_a[IRQ_MATCH] = hit_a & stat_a[ST_MATCH_EN];
        r.irq_b[IRQ_MATCH] = hit_b & stat_b[ST_MATCH_EN];
        stat_a[ST_HBLANK] = 1'b0;
        stat_b[ST_HBLANK] = 1'b0;
      end
      MODE_WRITE_A: stat_a = (stat_a & ~WRITE_MASK) | (data & WRITE_MASK);
      default:      stat_b = (stat_b & ~WRITE_MASK) | (data & WRITE_MASK);
    endcase
    r.line_count = line_q;
    r.status_a   = stat_a;
    r.status_b   = stat_b;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Checking: predict on every input transfer, compare on every result
  // transfer. Both sampled at the rising edge, inputs are stable there.
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin : result_monitor
    scan_result_t pred;
    scan_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pred = scanline_advance(in_mode, in_write_data);
        expected_q.push_back(row_typed ? row_exp : pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, line %0d",
                   $time, out_line_count);
          n_errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("line_count", 16'(want.line_count), 16'(out_line_count));
          check_field("status_a", want.status_a, out_status_a);
          check_field("status_b", want.status_b, out_status_b);
          check_field("irq_a", 16'(want.irq_a), 16'(out_irq_a));
          check_field("irq_b", 16'(want.irq_b), 16'(out_irq_b));
          check_field("dma_a_vblank", 16'(want.dma_a_vblank), 16'(out_dma_a_vblank));
          check_field("dma_b_vblank", 16'(want.dma_b_vblank), 16'(out_dma_b_vblank));
          check_field("dma_b_hblank", 16'(want.dma_b_hblank), 16'(out_dma_b_hblank));
          check_field("dma_b_display_start", 16'(want.dma_b_display_start),
                      16'(out_dma_b_display_start));
          check_field("render_line_valid", 16'(want.render_line_valid),
                      16'(out_render_line_valid));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall in phases, each with its own density, some with none
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_phase = $urandom_range(16, 96);
      case ($urandom_range(0, 4))
        0, 1: stall_pct = 0;
        2:    stall_pct = 30;
        3:    stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_phase--;
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Drive one event at the falling edge, hold it until the transfer. Between
  // bursts, drop valid for a random gap first.
  task automatic send_event(input logic [MODE_W-1:0] mode,
                            input logic [STATUS_W-1:0] data,
                            input logic typed, input scan_result_t exp);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_write_data <= data;
    row_typed     = typed;
    row_exp       = exp;
    burst_left--;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  // Status word with a chosen compare value and random enables; aim the compare
  // at the frame edges, just ahead of the current line, or anywhere in 0..511.
  function automatic logic [STATUS_W-1:0] status_word_pick();
    logic [LINE_W-1:0] cmp;
    case ($urandom_range(0, 7))
      0: cmp = '0;
      1: cmp = LINE_W'($urandom_range(VISIBLE_LINES - 1, VISIBLE_LINES + 1));
      2: cmp = LINE_W'(TOTAL_LINES - 1);
      3: cmp = line_q + 1'b1;
      4: cmp = line_q + 2'd2;
      5: cmp = LINE_W'($urandom_range(0, TOTAL_LINES - 1));
      6: cmp = LINE_W'($urandom_range(TOTAL_LINES, 511));
      default: cmp = '1;
    endcase
    return {cmp[7:0], cmp[8], 7'($urandom)};
  endfunction

  // Directed events. Typed results are read straight off the rules; the
  // rest go through the line model.
  initial begin
    dir_rows = '{
      // Hblank right after reset: line 0 is visible, nothing enabled
      '{MODE_HBLANK,  16'h0000, 1'b1, '{9'd0, 16'h0002, 16'h0002, 3'b000, 3'b000,
                                         1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
      // All ones into A: only writable bits land, hblank flag kept
      '{MODE_WRITE_A, 16'hFFFF, 1'b1, '{9'd0, 16'hFFBA, 16'h0002, 3'b000, 3'b000,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Only unwritable bits into B: nothing changes
      '{MODE_WRITE_B, 16'h0047, 1'b1, '{9'd0, 16'hFFBA, 16'h0002, 3'b000, 3'b000,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Repeated hblank with A enabled: irq though the flag is already set, data ignored
      '{MODE_HBLANK,  16'hFFFF, 1'b1, '{9'd0, 16'hFFBA, 16'h0002, 3'b010, 3'b000,
                                         1'b0, 1'b0, 1'b1, 1'b0, 1'b1}},
      // Line end: compare 511 on A never matches, hblank cleared
      '{MODE_LINEEND, 16'hFFFF, 1'b1, '{9'd1, 16'hFFB8, 16'h0000, 3'b000, 3'b000,
                                         1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // B compares against line 2, all enables on
      '{MODE_WRITE_B, 16'h0238, 1'b0, '0},
      '{MODE_LINEEND, 16'h0000, 1'b0, '0},
      '{MODE_HBLANK,  16'h1234, 1'b0, '0},
      '{MODE_HBLANK,  16'h0000, 1'b0, '0},
      '{MODE_WRITE_A, 16'h0000, 1'b0, '0},
      // A compares against line 0, match and vblank enabled
      '{MODE_WRITE_A, 16'h0028, 1'b0, '0},
      '{MODE_LINEEND, 16'h0000, 1'b0, '0},
      '{MODE_WRITE_B, 16'hAAAA, 1'b0, '0},
      '{MODE_WRITE_A, 16'h5555, 1'b0, '0},
      '{MODE_HBLANK,  16'h0000, 1'b0, '0},
      '{MODE_LINEEND, 16'h0000, 1'b0, '0},
      '{MODE_WRITE_B, 16'h0000, 1'b0, '0}
    };
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    bit drained;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_mode       = MODE_HBLANK;
    in_write_data = '0;
    out_stall     = 1'b0;
    row_typed     = 1'b0;
    row_exp       = '0;
    line_q        = '0;
    stat_a        = '0;
    stat_b        = '0;
    frame_wraps   = 0;
    n_errors      = 0;
    n_items       = 0;
    burst_left    = 0;
    stall_pct     = 0;
    stall_phase   = 0;
    drained       = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_event(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].exp);

    // Random scanlines until enough events and at least two frame wraps
    while (n_items < RAND_ITEMS || frame_wraps < MIN_WRAPS) begin
      // Once, midway: stop sending until every result is back
      if (!drained && n_items >= RAND_ITEMS / 2) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      // Stray event: any mode, any data
      if ($urandom_range(0, 9) == 0)
        send_event(MODE_W'($urandom), STATUS_W'($urandom), 1'b0, '0);
      if ($urandom_range(0, 5) == 0)
        send_event($urandom_range(0, 1) ? MODE_WRITE_A : MODE_WRITE_B,
                   status_word_pick(), 1'b0, '0);
      if ($urandom_range(0, 9) != 0) begin
        send_event(MODE_HBLANK, STATUS_W'($urandom), 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
          send_event(MODE_HBLANK, STATUS_W'($urandom), 1'b0, '0);
      end
      send_event(MODE_LINEEND, STATUS_W'($urandom), 1'b0, '0);
    end

    // Drain, then give stray results time to show up
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);

    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop if the handshake hangs
  initial begin
    #(LIMIT_NS);
    $display("%0t ns: timeout, %0d results outstanding", $time, expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
